// File: rtl/gufe_pkg.sv
package gufe_pkg;

  localparam int InWidth   = 16;
  localparam int WorkWidth = 64;
  localparam int MaxTerms  = 64;
  localparam int CntWidth  = $clog2(MaxTerms + 1);
  localparam int BitWidth  = $clog2(WorkWidth + 1);

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StInvalid  = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CEIL,
    S_MULN,
    S_MULD,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_OVF
  } gufe_state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                   go;
    logic [WorkWidth-1:0]   dividend;
    logic [WorkWidth-1:0]   divisor;
  } gufe_div_req_t;

  typedef struct packed {
    logic                   done;
    logic [WorkWidth-1:0]   quot;
    logic [WorkWidth-1:0]   rem;
  } gufe_div_rsp_t;

endpackage

// File: rtl/gufe_div.sv
module gufe_div (
  input  logic                   clk,
  input  logic                   rst,
  input  gufe_pkg::gufe_div_req_t req,
  output gufe_pkg::gufe_div_rsp_t rsp
);

  localparam int W = gufe_pkg::WorkWidth;

  logic             busy;
  logic [W-1:0]     quot;
  logic [W:0]       rem;
  logic [W-1:0]     dsr;
  logic [gufe_pkg::BitWidth-1:0] cnt;
  logic             done;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem[W-1:0], quot[W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= gufe_pkg::BitWidth'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == gufe_pkg::BitWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      quot <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem  <= diff;
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        quot <= {quot[W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem[W-1:0];

endmodule

// File: rtl/gufe_mul.sv
module gufe_mul (
  input  logic                           clk,
  input  logic                           start,
  input  logic [gufe_pkg::WorkWidth-1:0] a,
  input  logic [gufe_pkg::WorkWidth-1:0] b,
  output logic                           done,
  output logic [gufe_pkg::WorkWidth-1:0] prod,
  output logic                           ovf,
  input  logic                           rst
);

  localparam int W = gufe_pkg::WorkWidth;

  // Shift-add multiplier, one bit of b per cycle, with overflow tracking.
  logic [W-1:0] acc;
  logic [W:0]   mcand;
  logic         mc_big;
  logic [W-1:0] mplr;
  logic         over;
  logic         busy;
  logic [W:0]   sum;

  assign sum = {1'b0, acc} + {1'b0, mcand[W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && mplr == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= {1'b0, a};
      mc_big <= 1'b0;
      mplr   <= b;
      over   <= 1'b0;
    end else if (busy && mplr != '0) begin
      if (mplr[0]) begin
        acc <= sum[W-1:0];
        if (sum[W] || mc_big) over <= 1'b1;
      end
      mplr   <= mplr >> 1;
      mc_big <= mc_big | mcand[W-1];
      mcand  <= {1'b0, mcand[W-2:0], 1'b0};
    end
  end

  assign prod = acc;
  assign ovf  = over;

endmodule

// File: rtl/greedy_unit_fraction_expander_unit.sv
// Greedy unit-fraction expander. Raise start with a proper fraction on
// numerator and denominator while busy is low; the block then emits the
// greedy Egyptian-fraction terms one per strobe on unit_denominator, with
// last marking the final result of the item. An invalid fraction gives one
// result with status 1 in the cycle after it is taken, and the block stays
// ready. Work-width overflow or the 64-term limit ends the run with a status 2
// result. Every division goes through one bit-serial divider, and a term takes
// two multiplies. The ceiling costs one division, and the gcd costs one
// division per Euclid step, up to about 93 steps for 64-bit values. The two
// reducing divisions add two more. Results cannot be stalled.
module greedy_unit_fraction_expander_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] numerator,
  input  logic [15:0] denominator,
  output logic        strobe,
  output logic [63:0] unit_denominator,
  output logic [1:0]  status,
  output logic        last
);

  localparam int W = gufe_pkg::WorkWidth;

  gufe_pkg::gufe_state_t state, state_next;
  gufe_pkg::gufe_div_req_t dreq;
  gufe_pkg::gufe_div_rsp_t drsp;

  logic [W-1:0] num, den, c, na, nb, gx, gy;
  logic [gufe_pkg::CntWidth-1:0] n;
  logic         mstart, mdone, movf;
  logic [W-1:0] ma, mb, mprod;
  logic         pn_ovf;
  logic         div_sent;
  logic         bad_frac;

  gufe_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  gufe_mul u_mul (.clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb),
                  .done(mdone), .prod(mprod), .ovf(movf));

  assign bad_frac = numerator == '0 || denominator == '0 || numerator >= denominator;

  always_ff @(posedge clk) begin
    if (rst) state <= gufe_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != gufe_pkg::S_IDLE);

  always_comb begin
    state_next    = state;
    dreq.go       = 1'b0;
    dreq.dividend = den;
    dreq.divisor  = num;
    mstart        = 1'b0;
    ma            = num;
    mb            = c;
    unique case (state)
      gufe_pkg::S_IDLE: begin
        if (start && !bad_frac) state_next = gufe_pkg::S_CEIL;
      end
      gufe_pkg::S_CEIL: begin
        dreq.go = !div_sent;
        if (drsp.done) state_next = gufe_pkg::S_MULN;
      end
      gufe_pkg::S_MULN: begin
        mstart = !div_sent;
        if (mdone) state_next = gufe_pkg::S_MULD;
      end
      gufe_pkg::S_MULD: begin
        ma = den;
        mstart = !div_sent;
        if (mdone) state_next = gufe_pkg::S_CHECK;
      end
      gufe_pkg::S_CHECK: begin
        state_next = gufe_pkg::S_IDLE;
        if (!pn_ovf && na != '0 && n < gufe_pkg::CntWidth'(gufe_pkg::MaxTerms - 1)) begin
          if (pn_ovf || movf) state_next = gufe_pkg::S_OVF;
          else state_next = gufe_pkg::S_GCD;
        end else if (pn_ovf && n < gufe_pkg::CntWidth'(gufe_pkg::MaxTerms - 1)) begin
          state_next = gufe_pkg::S_OVF;
        end
      end
      gufe_pkg::S_GCD: begin
        dreq.dividend = gx;
        dreq.divisor  = gy;
        dreq.go = !div_sent && gy != '0;
        if (gy == '0) state_next = gufe_pkg::S_DIVN;
      end
      gufe_pkg::S_DIVN: begin
        dreq.dividend = na;
        dreq.divisor  = gx;
        dreq.go = !div_sent;
        if (drsp.done) state_next = gufe_pkg::S_DIVD;
      end
      gufe_pkg::S_DIVD: begin
        dreq.dividend = nb;
        dreq.divisor  = gx;
        dreq.go = !div_sent;
        if (drsp.done) state_next = gufe_pkg::S_CEIL;
      end
      gufe_pkg::S_OVF: state_next = gufe_pkg::S_IDLE;
      default: state_next = gufe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      div_sent <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      // A finished division frees the divider, so the gcd loop can issue the next step.
      div_sent <= (dreq.go || mstart || div_sent) && (state_next == state) && !drsp.done;
      unique case (state)
        gufe_pkg::S_IDLE: begin
          if (start) begin
            num <= W'(numerator);
            den <= W'(denominator);
            n   <= '0;
            if (bad_frac) begin
              strobe <= 1'b1;
              unit_denominator <= '0;
              status <= gufe_pkg::StInvalid;
              last <= 1'b1;
            end
          end
        end
        gufe_pkg::S_CEIL: begin
          if (drsp.done) c <= drsp.quot + W'(drsp.rem != '0);
        end
        gufe_pkg::S_MULN: begin
          if (mdone) begin
            na     <= mprod - den;
            pn_ovf <= movf;
          end
        end
        gufe_pkg::S_MULD: begin
          if (mdone) begin
            nb <= mprod;
            gx <= na;
            gy <= mprod;
          end
        end
        gufe_pkg::S_CHECK: begin
          strobe <= 1'b1;
          unit_denominator <= c;
          status <= gufe_pkg::StOk;
          last   <= 1'b0;
          n      <= n + 1'b1;
          if (!pn_ovf && na == '0) begin
            last <= 1'b1;
          end else if (n >= gufe_pkg::CntWidth'(gufe_pkg::MaxTerms - 1)) begin
            unit_denominator <= '0;
            status <= gufe_pkg::StOverflow;
            last   <= 1'b1;
          end
        end
        gufe_pkg::S_GCD: begin
          if (drsp.done) begin
            gx <= gy;
            gy <= drsp.rem;
          end
        end
        gufe_pkg::S_DIVN: if (drsp.done) num <= drsp.quot;
        gufe_pkg::S_DIVD: if (drsp.done) den <= drsp.quot;
        gufe_pkg::S_OVF: begin
          strobe <= 1'b1;
          unit_denominator <= '0;
          status <= gufe_pkg::StOverflow;
          last   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/gufe_checker.sv
module gufe_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [63:0] unit_denominator,
  input logic [1:0]  status,
  input logic        last
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (status == gufe_pkg::StOk || status == gufe_pkg::StInvalid ||
                status == gufe_pkg::StOverflow))
    else $error("bad status");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status != gufe_pkg::StOk |-> unit_denominator == '0 && last)
    else $error("error result malformed");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe && status == gufe_pkg::StOk |-> unit_denominator != '0)
    else $error("zero term");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy after last result");

endmodule

bind greedy_unit_fraction_expander_unit gufe_checker u_gufe_checker (.*);

// File: dv/greedy_unit_fraction_expander_unit_test.sv
`timescale 1ns / 100ps

module greedy_unit_fraction_expander_unit_test;

  localparam int IdleLimit = 200000;
  localparam int DrainWait = 20000;
  localparam int RandomItems = 240;

  typedef struct {
    logic [63:0] term;
    logic [1:0]  st;
    logic        fin;
  } term_t;

  typedef struct {
    logic [15:0] num;
    logic [15:0] den;
    logic        typed;
    logic [63:0] term;
    logic [1:0]  st;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] numerator = '0;
  logic [15:0] denominator = '0;
  logic        busy;
  logic        strobe;
  logic [63:0] unit_denominator;
  logic [1:0]  status;
  logic        last;

  term_t pending_terms[$];
  int    mismatch_count = 0;
  int    quiet_cycles = 0;
  logic  no_idle = 1'b0;

  greedy_unit_fraction_expander_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .numerator(numerator),
    .denominator(denominator),
    .strobe(strobe),
    .unit_denominator(unit_denominator),
    .status(status),
    .last(last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic push_term(logic [63:0] term, logic [1:0] st, logic fin);
    term_t t;
    t.term = term;
    t.st = st;
    t.fin = fin;
    pending_terms.push_back(t);
  endtask

  // Greedy expansion in 64-bit unsigned arithmetic, cut short on overflow or term limit.
  task automatic expand_fraction(logic [15:0] n_in, logic [15:0] d_in);
    longint unsigned num, den, c, na, nb, g, x, y, r;
    longint unsigned all_ones;
    int k;
    all_ones = '1;
    num = 64'(n_in);
    den = 64'(d_in);
    k = 0;
    if (num == 0 || den == 0 || num >= den) begin
      push_term('0, gufe_pkg::StInvalid, 1'b1);
      return;
    end
    forever begin
      c = den / num + (((den % num) != 0) ? 64'd1 : 64'd0);
      if (!(num > all_ones / c) && num * c == den) begin
        push_term(c, gufe_pkg::StOk, 1'b1);
        return;
      end
      if (k >= gufe_pkg::MaxTerms - 1) begin
        push_term('0, gufe_pkg::StOverflow, 1'b1);
        return;
      end
      if (num > all_ones / c || den > all_ones / c) begin
        push_term(c, gufe_pkg::StOk, 1'b0);
        push_term('0, gufe_pkg::StOverflow, 1'b1);
        return;
      end
      push_term(c, gufe_pkg::StOk, 1'b0);
      k++;
      na = num * c - den;
      nb = den * c;
      x = na;
      y = nb;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      g = (x == 0) ? 64'd1 : x;
      num = na / g;
      den = nb / g;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Hands one item over and records what it should produce.
  task automatic send_fraction(stim_row_t row);
    start <= 1'b1;
    numerator <= row.num;
    denominator <= row.den;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (row.typed) push_term(row.term, row.st, 1'b1);
    else expand_fraction(row.num, row.den);
    if (!no_idle && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    term_t want;
    if (!rst && strobe) begin
      if (pending_terms.size() == 0) begin
        report_mismatch("unexpected result", unit_denominator, '0);
      end else begin
        want = pending_terms.pop_front();
        if (unit_denominator !== want.term)
          report_mismatch("unit_denominator", unit_denominator, want.term);
        if (status !== want.st) report_mismatch("status", 64'(status), 64'(want.st));
        if (last !== want.fin) report_mismatch("last", 64'(last), 64'(want.fin));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t directed[$];
    stim_row_t row;
    logic [15:0] a, b;
    directed = '{
      '{16'd0,     16'd5,     1'b1, 64'd0,     gufe_pkg::StInvalid},
      '{16'd5,     16'd0,     1'b1, 64'd0,     gufe_pkg::StInvalid},
      '{16'd0,     16'd0,     1'b1, 64'd0,     gufe_pkg::StInvalid},
      '{16'd5,     16'd5,     1'b1, 64'd0,     gufe_pkg::StInvalid},
      '{16'd7,     16'd3,     1'b1, 64'd0,     gufe_pkg::StInvalid},
      '{16'hffff,  16'hffff,  1'b1, 64'd0,     gufe_pkg::StInvalid},
      '{16'hffff,  16'd1,     1'b1, 64'd0,     gufe_pkg::StInvalid},
      '{16'd1,     16'd2,     1'b1, 64'd2,     gufe_pkg::StOk},
      '{16'd1,     16'hffff,  1'b1, 64'd65535, gufe_pkg::StOk},
      '{16'h5555,  16'haaaa,  1'b1, 64'd2,     gufe_pkg::StOk},
      '{16'hfffe,  16'hffff,  1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'd2,     16'd3,     1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'd3,     16'd7,     1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'd4,     16'd13,    1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'd5,     16'd121,   1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'haaaa,  16'hffff,  1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'd32767, 16'd65521, 1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'd65533, 16'd65534, 1'b0, 64'd0,     gufe_pkg::StOk},
      '{16'd3,     16'd65535, 1'b0, 64'd0,     gufe_pkg::StOk}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_fraction(directed[i]);
    for (int i = 0; i < RandomItems; i++) begin
      no_idle = (i >= 60 && i < 120);
      if (i == 130) begin
        // Let the block drain completely before carrying on.
        start <= 1'b0;
        while (pending_terms.size() != 0) @(posedge clk);
        repeat (DrainWait) @(posedge clk);
      end
      a = 16'($urandom);
      b = 16'($urandom);
      if ($urandom_range(99) < 85) begin
        if (a == b) b = a + 16'd1;
        if (a > b) begin
          row.num = b;
          row.den = a;
        end else begin
          row.num = a;
          row.den = b;
        end
        if (row.num == 0) row.num = 1;
        if (row.num >= row.den) row.den = 16'hffff;
        if (row.num >= row.den) row.num = 16'd1;
      end else begin
        row.num = a;
        row.den = b;
      end
      row.typed = 1'b0;
      row.term = '0;
      row.st = gufe_pkg::StOk;
      send_fraction(row);
    end
    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gufe_pkg.sv
rtl/gufe_div.sv
rtl/gufe_mul.sv
rtl/greedy_unit_fraction_expander_unit.sv
rtl/gufe_checker.sv
dv/greedy_unit_fraction_expander_unit_test.sv
